[src/coverage_alpha_blend_blit_macros.svh]
// Assertion macros used by the blitter RTL.
`ifndef COVERAGE_ALPHA_BLEND_BLIT_MACROS_SVH
`define COVERAGE_ALPHA_BLEND_BLIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CABB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CABB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/cabb_pkg.sv]
package cabb_pkg;

  // Field widths of the pixel stream.
  localparam int COV_W   = 8;
  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;
  localparam int NCHAN   = 3;
  localparam int POS_W   = 12;
  localparam int PIX_W   = 13;
  localparam int DIM_W   = 13;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_BRUSH_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 3'd4;

  // Coverage codes with special meaning.
  localparam logic [COV_W-1:0] COV_NONE = 8'h00;
  localparam logic [COV_W-1:0] COV_FULL = 8'hff;

  localparam int MAX_DIM_DEF = 4096;

  // One finished pixel write.
  typedef struct packed {
    logic               write_enable;
    logic [COLOR_W-1:0] pixel_color;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic               last;
  } res_t;

  // bg + floor(cov * (br - bg) / 256), kept modulo 256. The low byte of the
  // arithmetic shift equals bits 15:8 of the signed product.
  function automatic logic [CHAN_W-1:0] blend_channel(
    input logic [COV_W-1:0]  cov,
    input logic [CHAN_W-1:0] br,
    input logic [CHAN_W-1:0] bg
  );
    logic signed [CHAN_W:0]     diff;
    logic signed [2*CHAN_W+1:0] prod;
    diff = $signed({1'b0, br}) - $signed({1'b0, bg});
    prod = (2*CHAN_W+2)'($signed({1'b0, cov})) * (2*CHAN_W+2)'(diff);
    return bg + prod[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

[src/coverage_alpha_blend_blit.sv]
// Pixels are registered at the output; the blend is three 9x9 signed multiplies.
// Throughput: one pixel per cycle while the skid register is empty.
// An output register backed by a one-entry skid register keeps input acceptance going
// for one more pixel while the output is stalled.
// Reset (synchronous, active high) clears the counters, the valid flags and the
// configuration registers; rectangle width and height reset to one.
`include "coverage_alpha_blend_blit_macros.svh"

module coverage_alpha_blend_blit #(
  parameter int MAX_DIM = cabb_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cabb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cabb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cabb_pkg::COV_W-1:0]      coverage,
  input  logic [cabb_pkg::COLOR_W-1:0]    background,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            write_enable,
  output logic [cabb_pkg::COLOR_W-1:0]    pixel_color,
  output logic [cabb_pkg::PIX_W-1:0]      pixel_x,
  output logic [cabb_pkg::PIX_W-1:0]      pixel_y,
  output logic                            last
);
  import cabb_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int CMP_W = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;

  logic [COLOR_W-1:0] brush_color;
  logic [POS_W-1:0]   dest_left;
  logic [POS_W-1:0]   dest_top;
  logic [DIM_W-1:0]   rect_width;
  logic [DIM_W-1:0]   rect_height;

  logic [CNT_W-1:0] column;
  logic [CNT_W-1:0] row;
  logic [CNT_W-1:0] column_next;
  logic [CNT_W-1:0] row_next;

  logic [CMP_W-1:0] width_eff;
  logic [CMP_W-1:0] height_eff;
  logic             row_end;
  logic             col_end;
  logic             in_fire;
  logic             out_fire;

  res_t res_comb;
  res_t out_res;
  res_t skid_res;
  logic skid_valid;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      brush_color <= '0;
      dest_left   <= '0;
      dest_top    <= '0;
      rect_width  <= DIM_W'(1);
      rect_height <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BRUSH_COLOR: brush_color <= cfg_data[COLOR_W-1:0];
        REG_DEST_LEFT:   dest_left   <= cfg_data[POS_W-1:0];
        REG_DEST_TOP:    dest_top    <= cfg_data[POS_W-1:0];
        REG_RECT_WIDTH:  rect_width  <= cfg_data[DIM_W-1:0];
        REG_RECT_HEIGHT: rect_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective size: zero acts as one, anything above the maximum acts as the maximum.
  always_comb begin
    if (rect_width == '0) begin
      width_eff = CMP_W'(1);
    end else if (CMP_W'(rect_width) > CMP_W'(MAX_DIM)) begin
      width_eff = CMP_W'(MAX_DIM);
    end else begin
      width_eff = CMP_W'(rect_width);
    end
    if (rect_height == '0) begin
      height_eff = CMP_W'(1);
    end else if (CMP_W'(rect_height) > CMP_W'(MAX_DIM)) begin
      height_eff = CMP_W'(MAX_DIM);
    end else begin
      height_eff = CMP_W'(rect_height);
    end
  end

  // Raster position. A counter at or past a shrunken size counts as at its end.
  assign row_end = (CMP_W'(column) + CMP_W'(1)) >= width_eff;
  assign col_end = (CMP_W'(row) + CMP_W'(1)) >= height_eff;

  always_comb begin
    column_next = column + CNT_W'(1);
    row_next    = row;
    if (row_end) begin
      column_next = '0;
      row_next    = col_end ? '0 : row + CNT_W'(1);
    end
  end

  // Per-pixel blend and address.
  always_comb begin
    res_comb.write_enable = (coverage != COV_NONE);
    res_comb.pixel_color  = '0;
    if (coverage == COV_FULL) begin
      res_comb.pixel_color = brush_color;
    end else if (coverage != COV_NONE) begin
      for (int k = 0; k < NCHAN; k++) begin
        res_comb.pixel_color[k*CHAN_W +: CHAN_W] =
          blend_channel(coverage, brush_color[k*CHAN_W +: CHAN_W],
                        background[k*CHAN_W +: CHAN_W]);
      end
    end
    res_comb.pixel_x = PIX_W'(CMP_W'(dest_left) + CMP_W'(column));
    res_comb.pixel_y = PIX_W'(CMP_W'(dest_top) + CMP_W'(row));
    res_comb.last    = row_end && col_end;
  end

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Counters advance once per accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (in_fire) begin
      column <= column_next;
      row    <= row_next;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && !out_fire) begin
        if (in_fire) begin
          skid_valid <= 1'b1;
        end
      end else if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_fire) begin
      if (in_fire) begin
        skid_res <= res_comb;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else if (in_fire) begin
      out_res <= res_comb;
    end
  end

  assign write_enable = out_res.write_enable;
  assign pixel_color  = out_res.pixel_color;
  assign pixel_x      = out_res.pixel_x;
  assign pixel_y      = out_res.pixel_y;
  assign last         = out_res.last;

  // A waiting skid entry always sits behind a held output.
  `CABB_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid entry without output entry")
  // A pixel that writes nothing carries a zero color.
  `CABB_ASSERT_NOW(a_no_write_zero, out_valid && !write_enable, pixel_color == '0, "color set on skipped pixel")
  // The final pixel returns the raster position to the origin.
  `CABB_ASSERT_NEXT(a_last_wraps, in_fire && res_comb.last, column == '0 && row == '0, "counters not cleared after last pixel")
  // Inside a row the column steps by one.
  `CABB_ASSERT_NEXT(a_column_step, in_fire && !row_end, column == CNT_W'($past(column) + CNT_W'(1)), "column did not advance by one")

endmodule
